/* design/pcdq_pkg.sv */
// Shared constants, codes and control/status types for the priority command deque.
// No dependencies; pcdq_ctrl, pcdq_datapath and the top level import this package.
package pcdq_pkg;

    // Queue geometry
    localparam int DEPTH   = 16;
    localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int DATA_W  = 16;
    localparam int KIND_W  = 16;
    localparam int ENTRY_W = DATA_W + KIND_W;
    localparam int MODE_W  = 2;
    localparam int STAT_W  = 2;
    localparam int RPT_W   = 5;

    // Operation codes
    localparam logic [MODE_W-1:0] MODE_PUSH = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PRIO = 2'd1;
    localparam logic [MODE_W-1:0] MODE_POP  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_PEEK = 2'd3;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    // Head reported on an empty queue
    localparam logic [DATA_W-1:0] EMPTY_DATA = 16'h0000;
    localparam logic [KIND_W-1:0] EMPTY_KIND = 16'h00FF;

    // RAM write source selection
    typedef enum logic [1:0] {
        W_PLAN      = 2'd0,   // planned slot, new item
        W_SWAP_HEAD = 2'd1,   // new head slot, old head entry
        W_SWAP_OLD  = 2'd2    // old head slot, new item
    } t_wsel;

    // Controller -> datapath commands
    typedef struct packed {
        logic  load;
        logic  we;
        t_wsel wsel;
        logic  re;
        logic  rd_old;
        logic  finish;
    } t_cmd;

    // Datapath -> controller status
    typedef struct packed {
        logic plan_swap;
        logic plan_write;
    } t_stat;

endpackage

/* design/pcdq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pcdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port, holds its value between reads
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/pcdq_ctrl.sv */
// Sequencer for the priority command deque: steps the datapath through each operation.
// Depends on pcdq_pkg.
module pcdq_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  pcdq_pkg::t_stat i_stat,
    output pcdq_pkg::t_cmd  o_cmd,
    output logic            o_busy,
    output logic            o_valid
);
    import pcdq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SWAP_WR1,
        S_SWAP_WR2,
        S_READ,
        S_WAIT
    } t_state;

    t_state r_state, n_state;
    logic   r_busy, n_busy;
    logic   r_valid, n_valid;
    t_cmd   cmd;

    // Next state and command decode
    always_comb begin
        n_state    = r_state;
        cmd        = '0;
        cmd.wsel   = W_PLAN;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    cmd.load = 1'b1;
                    n_state  = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (i_stat.plan_swap) begin
                    cmd.re     = 1'b1;
                    cmd.rd_old = 1'b1;
                    n_state    = S_SWAP_WR1;
                end else if (i_stat.plan_write) begin
                    cmd.we  = 1'b1;
                    n_state = S_READ;
                end else begin
                    cmd.re  = 1'b1;
                    n_state = S_WAIT;
                end
            end
            S_SWAP_WR1: begin
                cmd.we   = 1'b1;
                cmd.wsel = W_SWAP_HEAD;
                n_state  = S_SWAP_WR2;
            end
            S_SWAP_WR2: begin
                cmd.we   = 1'b1;
                cmd.wsel = W_SWAP_OLD;
                n_state  = S_READ;
            end
            S_READ: begin
                cmd.re  = 1'b1;
                n_state = S_WAIT;
            end
            S_WAIT: begin
                cmd.finish = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_busy  = (n_state != S_IDLE);
        n_valid = (r_state == S_WAIT);
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
            r_valid <= n_valid;
        end
    end

    assign o_cmd   = cmd;
    assign o_busy  = r_busy;
    assign o_valid = r_valid;

`ifndef ASSERT_OFF
    // A result beat is shown only once the sequencer is back to idle
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_state == S_IDLE && !r_busy))
        else $error("result strobe while sequencer active");

    // Result strobe lasts exactly one cycle
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |=> !r_valid)
        else $error("result strobe longer than one cycle");

    // An accepted beat starts the sequence and raises busy
    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !r_busy) |=> (r_state == S_DISPATCH && r_busy))
        else $error("accepted beat did not start an operation");

    // Second swap write always follows the first
    a_swap_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWAP_WR2) |-> ($past(r_state) == S_SWAP_WR1))
        else $error("swap writes out of order");
`endif

endmodule

/* design/pcdq_datapath.sv */
// Datapath of the priority command deque: pointers, count, entry RAM and result registers.
// Depends on pcdq_pkg and pcdq_ram.
module pcdq_datapath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  pcdq_pkg::t_cmd                 i_cmd,
    output pcdq_pkg::t_stat                o_stat,
    input  logic [pcdq_pkg::MODE_W-1:0]    i_mode,
    input  logic [pcdq_pkg::DATA_W-1:0]    i_item_data,
    input  logic [pcdq_pkg::KIND_W-1:0]    i_item_kind,
    input  logic                           i_head_in_flight,
    output logic [pcdq_pkg::STAT_W-1:0]    o_status,
    output logic [pcdq_pkg::RPT_W-1:0]     o_entry_count_out,
    output logic [pcdq_pkg::RPT_W-1:0]     o_reported_value,
    output logic [pcdq_pkg::DATA_W-1:0]    o_head_data,
    output logic [pcdq_pkg::KIND_W-1:0]    o_head_kind
);
    import pcdq_pkg::*;

    // Control state
    logic [PTR_W-1:0]  r_head, n_head;
    logic [PTR_W-1:0]  r_tail, n_tail;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_swap, n_swap;
    logic              r_write, n_write;

    // Per-operation payload
    logic [STAT_W-1:0] r_status, n_status;
    logic [RPT_W-1:0]  r_reported, n_reported;
    logic [PTR_W-1:0]  r_waddr, n_waddr;
    logic [PTR_W-1:0]  r_old, n_old;
    logic [DATA_W-1:0] r_data;
    logic [KIND_W-1:0] r_kind;

    // Result registers
    logic [STAT_W-1:0] r_out_status;
    logic [RPT_W-1:0]  r_out_count;
    logic [RPT_W-1:0]  r_out_reported;
    logic [DATA_W-1:0] r_out_data;
    logic [KIND_W-1:0] r_out_kind;

    logic [PTR_W-1:0]  head_inc, head_dec, tail_inc;
    logic              is_empty, is_full;
    logic [MODE_W-1:0] eff_mode;

    logic              ram_we, ram_re;
    logic [PTR_W-1:0]  ram_waddr, ram_raddr;
    logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

    // Wrapping pointer neighbors
    always_comb begin
        head_inc = (r_head == PTR_W'(DEPTH - 1)) ? '0 : r_head + 1'b1;
        head_dec = (r_head == '0) ? PTR_W'(DEPTH - 1) : r_head - 1'b1;
        tail_inc = (r_tail == PTR_W'(DEPTH - 1)) ? '0 : r_tail + 1'b1;
        is_empty = (r_count == '0);
        is_full  = (r_count == CNT_W'(DEPTH));
        // priority push into an empty queue behaves as a normal push
        eff_mode = (i_mode == MODE_PRIO && is_empty) ? MODE_PUSH : i_mode;
    end

    // Plan the operation from the incoming beat
    always_comb begin
        n_head     = r_head;
        n_tail     = r_tail;
        n_count    = r_count;
        n_swap     = 1'b0;
        n_write    = 1'b0;
        n_status   = ST_OK;
        n_reported = '0;
        n_waddr    = r_waddr;
        n_old      = r_old;
        case (eff_mode)
            MODE_PUSH: begin
                if (is_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_tail     = tail_inc;
                    n_waddr    = tail_inc;
                    n_count    = r_count + 1'b1;
                    n_reported = RPT_W'(r_count + 1'b1);
                    n_write    = 1'b1;
                end
            end
            MODE_PRIO: begin
                if (is_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_head     = head_dec;
                    n_old      = r_head;
                    n_reported = RPT_W'(r_head);
                    n_count    = r_count + 1'b1;
                    if (i_head_in_flight) begin
                        n_swap = 1'b1;
                    end else begin
                        n_waddr = head_dec;
                        n_write = 1'b1;
                    end
                end
            end
            MODE_POP: begin
                if (is_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_count = r_count - 1'b1;
                    n_head  = head_inc;
                end
            end
            default: begin
                if (is_empty) begin
                    n_status = ST_EMPTY;
                end
            end
        endcase
    end

    // Control state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= PTR_W'(DEPTH - 1);
            r_count <= '0;
            r_swap  <= 1'b0;
            r_write <= 1'b0;
        end else if (i_cmd.load) begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_swap  <= n_swap;
            r_write <= n_write;
        end
    end

    // Payload captured with the beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_status   <= n_status;
            r_reported <= n_reported;
            r_waddr    <= n_waddr;
            r_old      <= n_old;
            r_data     <= i_item_data;
            r_kind     <= i_item_kind;
        end
    end

    // RAM port steering
    always_comb begin
        ram_we    = i_cmd.we;
        ram_re    = i_cmd.re;
        ram_raddr = i_cmd.rd_old ? r_old : r_head;
        case (i_cmd.wsel)
            W_SWAP_HEAD: begin
                ram_waddr = r_head;
                ram_wdata = ram_rdata;
            end
            W_SWAP_OLD: begin
                ram_waddr = r_old;
                ram_wdata = {r_kind, r_data};
            end
            default: begin
                ram_waddr = r_waddr;
                ram_wdata = {r_kind, r_data};
            end
        endcase
    end

    pcdq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Result capture; empty queue reports the fixed empty head
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_status   <= r_status;
            r_out_count    <= RPT_W'(r_count);
            r_out_reported <= r_reported;
            if (r_count == '0) begin
                r_out_data <= EMPTY_DATA;
                r_out_kind <= EMPTY_KIND;
            end else begin
                r_out_data <= ram_rdata[DATA_W-1:0];
                r_out_kind <= ram_rdata[ENTRY_W-1:DATA_W];
            end
        end
    end

    assign o_stat.plan_swap  = r_swap;
    assign o_stat.plan_write = r_write;

    assign o_status          = r_out_status;
    assign o_entry_count_out = r_out_count;
    assign o_reported_value  = r_out_reported;
    assign o_head_data       = r_out_data;
    assign o_head_kind       = r_out_kind;

endmodule

/* design/priority_command_deque_core.sv */
// Top level of the priority command deque: sequencer plus datapath.
// Depends on pcdq_pkg, pcdq_ctrl and pcdq_datapath.
//
// A command beat is taken at a clock edge where start is high and busy is low. Every
// command gives exactly one result beat, held on the o_ result ports for one cycle with
// o_valid high; the receiver cannot stall it, so it must take each beat as it comes.
// Pop, peek and rejected pushes read the head in the dispatch state and then wait. A
// normal push and a priority push write in dispatch, then read the head and wait. A
// priority push with the head in flight reads the old head, makes both swap writes,
// then reads the head and waits. o_valid is registered from the wait state. busy falls
// in the cycle o_valid rises, so the next command may be given then and is taken at
// the edge that ends the result beat. The sequence follows from the entry RAM, whose
// read data is registered: a push writes the entry and then reads the head, and a swap
// reads the old head before its two writes.
module priority_command_deque_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [pcdq_pkg::MODE_W-1:0] i_mode,
    input  logic [pcdq_pkg::DATA_W-1:0] i_item_data,
    input  logic [pcdq_pkg::KIND_W-1:0] i_item_kind,
    input  logic                        i_head_in_flight,
    output logic                        o_valid,
    output logic [pcdq_pkg::STAT_W-1:0] o_status,
    output logic [pcdq_pkg::RPT_W-1:0]  o_entry_count_out,
    output logic [pcdq_pkg::RPT_W-1:0]  o_reported_value,
    output logic [pcdq_pkg::DATA_W-1:0] o_head_data,
    output logic [pcdq_pkg::KIND_W-1:0] o_head_kind
);
    import pcdq_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // Sequencer
    pcdq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_valid (o_valid)
    );

    // Pointers, store and results
    pcdq_datapath u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_mode            (i_mode),
        .i_item_data       (i_item_data),
        .i_item_kind       (i_item_kind),
        .i_head_in_flight  (i_head_in_flight),
        .o_status          (o_status),
        .o_entry_count_out (o_entry_count_out),
        .o_reported_value  (o_reported_value),
        .o_head_data       (o_head_data),
        .o_head_kind       (o_head_kind)
    );

endmodule
